// ===== sv/aam_pkg.sv =====
// ----------------------------------------------------------------------------
// Antenna amplitude modulation package
// Shared widths, register indexes and fixed-point rounding helpers.
// ----------------------------------------------------------------------------
package aam_pkg;

  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned IN_W          = 18;
  localparam int unsigned OUT_W         = 20;
  localparam int unsigned REG_IDX_W     = 3;
  localparam int unsigned QDEPTH        = 4;
  localparam int unsigned ACC_W         = 64;
  localparam int unsigned MAX_E         = 30;

  localparam logic signed [IN_W-1:0] CPH_RST = IN_W'(65536);

  typedef logic signed [ACC_W-1:0] acc_t;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_C1,
    REG_C2,
    REG_C3,
    REG_C4,
    REG_C5,
    REG_CPH,
    REG_SPH
  } reg_idx_e;

  // Exponent of the intermediate saturation range.
  function automatic int unsigned lim_exp(input int unsigned frac);
    return (frac + 7 < MAX_E) ? frac + 7 : MAX_E;
  endfunction

  // Exponent of the output clipping limit.
  function automatic int unsigned out_exp(input int unsigned frac);
    return (frac + 3 < OUT_W - 1) ? frac + 3 : OUT_W - 1;
  endfunction

  // Width of one item passed from the front end to the back end.
  function automatic int unsigned item_width(input int unsigned frac);
    return 4 * (lim_exp(frac) + 1) + 2 * IN_W + 1;
  endfunction

  function automatic acc_t sat_lim(input acc_t x, input int unsigned e);
    acc_t hi;
    acc_t lo;
    acc_t r;
    hi = (acc_t'(1) <<< e) - acc_t'(1);
    lo = -hi - acc_t'(1);
    if (x > hi) begin
      r = hi;
    end else if (x < lo) begin
      r = lo;
    end else begin
      r = x;
    end
    return r;
  endfunction

  // Round half up at the binary point, then saturate.
  function automatic acc_t rnd_sat(input acc_t p, input int unsigned frac,
                                   input int unsigned e);
    acc_t half;
    acc_t t;
    half = acc_t'(1) <<< (frac - 1);
    t = (p + half) >>> frac;
    return sat_lim(t, e);
  endfunction

endpackage

// ===== sv/aam_in_if.sv =====
// ----------------------------------------------------------------------------
// Sample input channel
// Valid/ready channel carrying one sky position and rotation phase sample.
// ----------------------------------------------------------------------------
interface aam_in_if;
  import aam_pkg::*;

  logic                   valid;
  logic                   ready;
  logic signed [IN_W-1:0] sin_ra;
  logic signed [IN_W-1:0] cos_ra;
  logic signed [IN_W-1:0] sin_dec;
  logic signed [IN_W-1:0] cos_dec;
  logic signed [IN_W-1:0] cos_mod;
  logic signed [IN_W-1:0] sin_mod;
  logic                   run_end;

  modport source (
    output valid, sin_ra, cos_ra, sin_dec, cos_dec, cos_mod, sin_mod, run_end,
    input  ready
  );

  modport sink (
    input  valid, sin_ra, cos_ra, sin_dec, cos_dec, cos_mod, sin_mod, run_end,
    output ready
  );

endinterface

// ===== sv/aam_out_if.sv =====
// ----------------------------------------------------------------------------
// Result output channel
// Valid/ready channel carrying the modulation factors of one sample.
// ----------------------------------------------------------------------------
interface aam_out_if;
  import aam_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] amp_a;
  logic signed [OUT_W-1:0] amp_b;
  logic                    run_end_out;
  logic                    saturated;

  modport source (
    output valid, amp_a, amp_b, run_end_out, saturated,
    input  ready
  );

  modport sink (
    input  valid, amp_a, amp_b, run_end_out, saturated,
    output ready
  );

endinterface

// ===== sv/aam_front.sv =====
// ----------------------------------------------------------------------------
// Antenna amplitude modulation front end
// Rotates right ascension by the detector phase and then by the modulation
// phase, and forms c, s and the declination terms in a four-stage pipeline.
// ----------------------------------------------------------------------------
module aam_front #(
  parameter int unsigned FRAC_BITS = aam_pkg::FRAC_BITS_DEF
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  aam_in_if.sink                                    in_i,
  input  logic signed [aam_pkg::IN_W-1:0]           cph_i,
  input  logic signed [aam_pkg::IN_W-1:0]           sph_i,
  output logic                                      item_valid_o,
  input  logic                                      item_ready_i,
  output logic [aam_pkg::item_width(FRAC_BITS)-1:0] item_o
);
  import aam_pkg::*;

  localparam int unsigned LIM_E = lim_exp(FRAC_BITS);
  localparam int unsigned IW    = LIM_E + 1;
  localparam int unsigned PW1   = 2 * IN_W;
  localparam int unsigned PW2   = IW + IN_W;

  function automatic logic signed [IW-1:0] rnd(input acc_t p);
    return IW'(rnd_sat(p, FRAC_BITS, LIM_E));
  endfunction

  logic en;
  logic v1_q, v2_q, v3_q, v4_q;

  logic signed [PW1-1:0]  p_crc1_q, p_crs1_q, p_src1_q, p_srs1_q, p_cdd1_q, p_sdc1_q;
  logic signed [IN_W-1:0] cmo1_q, smo1_q, sde1_q, cde1_q;
  logic                   end1_q;

  logic signed [IW-1:0]   cr2_q, sr2_q, c2d2_q, csd2_q;
  logic signed [IN_W-1:0] cmo2_q, smo2_q, sde2_q, cde2_q;
  logic                   end2_q;

  logic signed [PW2-1:0]  pa3_q, pb3_q, pc3_q, pd3_q;
  logic signed [IW-1:0]   c2d3_q, csd3_q;
  logic signed [IN_W-1:0] sde3_q, cde3_q;
  logic                   end3_q;

  logic signed [IW-1:0]   c4_q, s4_q, c2d4_q, csd4_q;
  logic signed [IN_W-1:0] sde4_q, cde4_q;
  logic                   end4_q;

  assign en           = !v4_q || item_ready_i;
  assign in_i.ready   = en;
  assign item_valid_o = v4_q;
  assign item_o       = {end4_q, cde4_q, sde4_q, csd4_q, c2d4_q, s4_q, c4_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_i.valid;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_crc1_q <= in_i.cos_ra * cph_i;
      p_crs1_q <= in_i.sin_ra * sph_i;
      p_src1_q <= in_i.sin_ra * cph_i;
      p_srs1_q <= in_i.cos_ra * sph_i;
      p_cdd1_q <= in_i.cos_dec * in_i.cos_dec;
      p_sdc1_q <= in_i.sin_dec * in_i.cos_dec;
      cmo1_q   <= in_i.cos_mod;
      smo1_q   <= in_i.sin_mod;
      sde1_q   <= in_i.sin_dec;
      cde1_q   <= in_i.cos_dec;
      end1_q   <= in_i.run_end;

      cr2_q  <= rnd(acc_t'(p_crc1_q) + acc_t'(p_crs1_q));
      sr2_q  <= rnd(acc_t'(p_src1_q) - acc_t'(p_srs1_q));
      c2d2_q <= rnd(acc_t'(p_cdd1_q));
      csd2_q <= rnd(acc_t'(p_sdc1_q));
      cmo2_q <= cmo1_q;
      smo2_q <= smo1_q;
      sde2_q <= sde1_q;
      cde2_q <= cde1_q;
      end2_q <= end1_q;

      pa3_q  <= cr2_q * cmo2_q;
      pb3_q  <= sr2_q * smo2_q;
      pc3_q  <= sr2_q * cmo2_q;
      pd3_q  <= cr2_q * smo2_q;
      c2d3_q <= c2d2_q;
      csd3_q <= csd2_q;
      sde3_q <= sde2_q;
      cde3_q <= cde2_q;
      end3_q <= end2_q;

      c4_q   <= rnd(acc_t'(pa3_q) + acc_t'(pb3_q));
      s4_q   <= rnd(acc_t'(pc3_q) - acc_t'(pd3_q));
      c2d4_q <= c2d3_q;
      csd4_q <= csd3_q;
      sde4_q <= sde3_q;
      cde4_q <= cde3_q;
      end4_q <= end3_q;
    end
  end

endmodule

// ===== sv/aam_queue.sv =====
// ----------------------------------------------------------------------------
// Antenna amplitude modulation queue
// Small first-in first-out buffer between the front end and the back end.
// ----------------------------------------------------------------------------
module aam_queue #(
  parameter int unsigned DATA_W = 1,
  parameter int unsigned DEPTH  = aam_pkg::QDEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_valid_i,
  output logic              wr_ready_o,
  input  logic [DATA_W-1:0] wr_data_i,
  output logic              rd_valid_o,
  input  logic              rd_ready_i,
  output logic [DATA_W-1:0] rd_data_o
);
  import aam_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              push, pop;

  assign wr_ready_o = cnt_q != CNT_W'(DEPTH);
  assign rd_valid_o = cnt_q != '0;
  assign rd_data_o  = mem_q[rd_ptr_q];
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

// ===== sv/aam_back.sv =====
// ----------------------------------------------------------------------------
// Antenna amplitude modulation back end
// Evaluates the two quadratic forms with the detector coefficients and
// clips the results into the output register.
// ----------------------------------------------------------------------------
module aam_back #(
  parameter int unsigned FRAC_BITS = aam_pkg::FRAC_BITS_DEF
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      item_valid_i,
  output logic                                      item_ready_o,
  input  logic [aam_pkg::item_width(FRAC_BITS)-1:0] item_i,
  input  logic signed [aam_pkg::IN_W-1:0]           coef_c1_i,
  input  logic signed [aam_pkg::IN_W-1:0]           coef_c2_i,
  input  logic signed [aam_pkg::IN_W-1:0]           coef_c3_i,
  input  logic signed [aam_pkg::IN_W-1:0]           coef_c4_i,
  input  logic signed [aam_pkg::IN_W-1:0]           coef_c5_i,
  aam_out_if.source                                 out_o
);
  import aam_pkg::*;

  localparam int unsigned LIM_E = lim_exp(FRAC_BITS);
  localparam int unsigned IW    = LIM_E + 1;
  localparam int unsigned QW    = item_width(FRAC_BITS);
  localparam int unsigned SW    = IW + 3;
  localparam int unsigned OUT_E = out_exp(FRAC_BITS);
  localparam acc_t OUT_HI = (acc_t'(1) <<< OUT_E) - acc_t'(1);
  localparam acc_t OUT_LO = -(acc_t'(1) <<< OUT_E);

  function automatic logic signed [IW-1:0] rnd(input acc_t p);
    return IW'(rnd_sat(p, FRAC_BITS, LIM_E));
  endfunction

  function automatic logic signed [IW-1:0] rnd2(input acc_t p);
    return IW'(sat_lim(rnd_sat(p, FRAC_BITS, LIM_E) <<< 1, LIM_E));
  endfunction

  logic signed [IW-1:0]   q_c, q_s, q_c2d, q_csd;
  logic signed [IN_W-1:0] q_sde, q_cde;
  logic                   q_end;
  logic signed [IN_W+1:0] c6;
  logic signed [IN_W:0]   c7, c8;
  logic signed [IW-1:0]   k_d;

  logic en;
  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, ov_q;

  logic signed [2*IW-1:0]      pcc1_q, pcs1_q;
  logic signed [IN_W+IW-1:0]   p51_q, p31_q, p41_q;
  logic signed [2*IN_W+1:0]    p61_q;
  logic signed [2*IN_W:0]      p71_q, p81_q;
  logic signed [2*IN_W-1:0]    p91_q;
  logic signed [IW-1:0]        k1_q, c_s1_q, s_s1_q;
  logic                        end1_q;

  logic signed [IW-1:0]        c2s2_q, cs22_q, m52_q, c6s2_q, c7s2_q, c8c2_q, c9c2_q;
  logic signed [IW-1:0]        c3d2_q, c4d2_q, c_s2_q, s_s2_q;
  logic signed [IN_W+IW-1:0]   pc1k2_q, pc2k2_q;
  logic                        end2_q;

  logic signed [IW-1:0]        c1k3_q, c2k3_q, c2s3_q, cs23_q, m53_q, c6s3_q;
  logic signed [2*IW-1:0]      pb63_q, pb73_q, pb83_q, pb93_q, pa33_q, pa43_q;
  logic                        end3_q;

  logic signed [2*IW-1:0]      pa14_q, pa24_q;
  logic signed [IW-1:0]        a34_q, a44_q, b64_q, b74_q, b84_q, b94_q;
  logic signed [IW-1:0]        c1k4_q, m54_q, c6s4_q;
  logic                        end4_q;

  logic signed [IW-1:0]        a15_q, a25_q, a35_q, a45_q, b65_q, b75_q, b85_q, b95_q;
  logic signed [IW-1:0]        c1k5_q, m55_q, c6s5_q;
  logic                        end5_q;

  logic signed [SW-1:0]        asum6_q, bsum6_q;
  logic                        end6_q;

  acc_t                        a_wide, b_wide;
  logic signed [OUT_W-1:0]     amp_a_d, amp_b_d, amp_a_q, amp_b_q;
  logic                        sat_a, sat_b, sat_q, end_q;

  assign q_c   = $signed(item_i[IW-1:0]);
  assign q_s   = $signed(item_i[2*IW-1:IW]);
  assign q_c2d = $signed(item_i[3*IW-1:2*IW]);
  assign q_csd = $signed(item_i[4*IW-1:3*IW]);
  assign q_sde = $signed(item_i[4*IW+IN_W-1:4*IW]);
  assign q_cde = $signed(item_i[4*IW+2*IN_W-1:4*IW+IN_W]);
  assign q_end = item_i[QW-1];

  assign c6  = -((IN_W+2)'(coef_c2_i) <<< 1);
  assign c7  = (IN_W+1)'(coef_c1_i) <<< 1;
  assign c8  = -((IN_W+1)'(coef_c4_i));
  assign k_d = IW'(sat_lim((acc_t'(1) <<< (FRAC_BITS + 1)) - acc_t'(q_c2d), LIM_E));

  assign en           = !ov_q || out_o.ready;
  assign item_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      ov_q <= 1'b0;
    end else if (en) begin
      v1_q <= item_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      v6_q <= v5_q;
      ov_q <= v6_q;
    end
  end

  always_comb begin
    a_wide  = acc_t'(asum6_q);
    b_wide  = acc_t'(bsum6_q);
    sat_a   = 1'b0;
    sat_b   = 1'b0;
    amp_a_d = OUT_W'(a_wide);
    amp_b_d = OUT_W'(b_wide);
    if (a_wide > OUT_HI) begin
      amp_a_d = OUT_W'(OUT_HI);
      sat_a   = 1'b1;
    end else if (a_wide < OUT_LO) begin
      amp_a_d = OUT_W'(OUT_LO);
      sat_a   = 1'b1;
    end
    if (b_wide > OUT_HI) begin
      amp_b_d = OUT_W'(OUT_HI);
      sat_b   = 1'b1;
    end else if (b_wide < OUT_LO) begin
      amp_b_d = OUT_W'(OUT_LO);
      sat_b   = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pcc1_q <= q_c * q_c;
      pcs1_q <= q_c * q_s;
      p51_q  <= coef_c5_i * q_c2d;
      p61_q  <= c6 * q_sde;
      p71_q  <= c7 * q_sde;
      p81_q  <= c8 * q_cde;
      p91_q  <= coef_c3_i * q_cde;
      p31_q  <= coef_c3_i * q_csd;
      p41_q  <= coef_c4_i * q_csd;
      k1_q   <= k_d;
      c_s1_q <= q_c;
      s_s1_q <= q_s;
      end1_q <= q_end;

      c2s2_q  <= rnd2(acc_t'(pcc1_q));
      cs22_q  <= rnd2(acc_t'(pcs1_q));
      m52_q   <= rnd(acc_t'(p51_q));
      c6s2_q  <= rnd(acc_t'(p61_q));
      c7s2_q  <= rnd(acc_t'(p71_q));
      c8c2_q  <= rnd(acc_t'(p81_q));
      c9c2_q  <= rnd(acc_t'(p91_q));
      c3d2_q  <= rnd(acc_t'(p31_q));
      c4d2_q  <= rnd(acc_t'(p41_q));
      pc1k2_q <= coef_c1_i * k1_q;
      pc2k2_q <= coef_c2_i * k1_q;
      c_s2_q  <= c_s1_q;
      s_s2_q  <= s_s1_q;
      end2_q  <= end1_q;

      c1k3_q <= rnd(acc_t'(pc1k2_q));
      c2k3_q <= rnd(acc_t'(pc2k2_q));
      pb63_q <= c6s2_q * c2s2_q;
      pb73_q <= c7s2_q * cs22_q;
      pb83_q <= c8c2_q * c_s2_q;
      pb93_q <= c9c2_q * s_s2_q;
      pa33_q <= c3d2_q * c_s2_q;
      pa43_q <= c4d2_q * s_s2_q;
      c2s3_q <= c2s2_q;
      cs23_q <= cs22_q;
      m53_q  <= m52_q;
      c6s3_q <= c6s2_q;
      end3_q <= end2_q;

      pa14_q <= c1k3_q * c2s3_q;
      pa24_q <= c2k3_q * cs23_q;
      a34_q  <= rnd(acc_t'(pa33_q));
      a44_q  <= rnd(acc_t'(pa43_q));
      b64_q  <= rnd(acc_t'(pb63_q));
      b74_q  <= rnd(acc_t'(pb73_q));
      b84_q  <= rnd(acc_t'(pb83_q));
      b94_q  <= rnd(acc_t'(pb93_q));
      c1k4_q <= c1k3_q;
      m54_q  <= m53_q;
      c6s4_q <= c6s3_q;
      end4_q <= end3_q;

      a15_q  <= rnd(acc_t'(pa14_q));
      a25_q  <= rnd(acc_t'(pa24_q));
      a35_q  <= a34_q;
      a45_q  <= a44_q;
      b65_q  <= b64_q;
      b75_q  <= b74_q;
      b85_q  <= b84_q;
      b95_q  <= b94_q;
      c1k5_q <= c1k4_q;
      m55_q  <= m54_q;
      c6s5_q <= c6s4_q;
      end5_q <= end4_q;

      asum6_q <= SW'(a15_q) + SW'(a25_q) + SW'(a35_q) + SW'(a45_q)
                 - SW'(c1k5_q) + SW'(m55_q);
      bsum6_q <= SW'(b65_q) + SW'(b75_q) + SW'(b85_q) + SW'(b95_q) - SW'(c6s5_q);
      end6_q  <= end5_q;

      amp_a_q <= amp_a_d;
      amp_b_q <= amp_b_d;
      sat_q   <= sat_a || sat_b;
      end_q   <= end6_q;
    end
  end

  assign out_o.valid       = ov_q;
  assign out_o.amp_a       = amp_a_q;
  assign out_o.amp_b       = amp_b_q;
  assign out_o.run_end_out = end_q;
  assign out_o.saturated   = sat_q;

endmodule

// ===== sv/antenna_amplitude_modulation.sv =====
// A result passes the front-end stages, the queue and the back-end stages before it is valid.
// Throughput: one sample per cycle unless stalled, set by fully pipelined multiplier stages.
// A four-entry queue lets the input keep taking samples while the output stalls briefly.
// Reset clears all pipeline valid flags and the queue, and loads the register defaults.
// ----------------------------------------------------------------------------
// Antenna amplitude modulation top level
// Holds the configuration registers and joins the front end, queue and back end.
// ----------------------------------------------------------------------------
module antenna_amplitude_modulation #(
  parameter int unsigned FRAC_BITS = aam_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [aam_pkg::REG_IDX_W-1:0]     cfg_idx_i,
  input  logic [aam_pkg::IN_W-1:0]          cfg_data_i,
  aam_in_if.sink                            in_i,
  aam_out_if.source                         out_o
);
  import aam_pkg::*;

  localparam int unsigned QW = item_width(FRAC_BITS);

  logic signed [IN_W-1:0] c1_q, c2_q, c3_q, c4_q, c5_q, cph_q, sph_q;

  logic          f_valid, f_ready, b_valid, b_ready;
  logic [QW-1:0] f_item, b_item;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c1_q  <= '0;
      c2_q  <= '0;
      c3_q  <= '0;
      c4_q  <= '0;
      c5_q  <= '0;
      cph_q <= CPH_RST;
      sph_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_C1:  c1_q  <= $signed(cfg_data_i);
        REG_C2:  c2_q  <= $signed(cfg_data_i);
        REG_C3:  c3_q  <= $signed(cfg_data_i);
        REG_C4:  c4_q  <= $signed(cfg_data_i);
        REG_C5:  c5_q  <= $signed(cfg_data_i);
        REG_CPH: cph_q <= $signed(cfg_data_i);
        REG_SPH: sph_q <= $signed(cfg_data_i);
        default: ;
      endcase
    end
  end

  aam_front #(
    .FRAC_BITS(FRAC_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cph_i       (cph_q),
    .sph_i       (sph_q),
    .item_valid_o(f_valid),
    .item_ready_i(f_ready),
    .item_o      (f_item)
  );

  aam_queue #(
    .DATA_W(QW),
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_valid_i(f_valid),
    .wr_ready_o(f_ready),
    .wr_data_i (f_item),
    .rd_valid_o(b_valid),
    .rd_ready_i(b_ready),
    .rd_data_o (b_item)
  );

  aam_back #(
    .FRAC_BITS(FRAC_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_valid_i(b_valid),
    .item_ready_o(b_ready),
    .item_i      (b_item),
    .coef_c1_i   (c1_q),
    .coef_c2_i   (c2_q),
    .coef_c3_i   (c3_q),
    .coef_c4_i   (c4_q),
    .coef_c5_i   (c5_q),
    .out_o       (out_o)
  );

endmodule

// ===== sv/aam_checker.sv =====
// ----------------------------------------------------------------------------
// Antenna amplitude modulation checker
// Port-level properties of the top level, attached through a bind.
// ----------------------------------------------------------------------------
module aam_checker #(
  parameter int unsigned FRAC_BITS = aam_pkg::FRAC_BITS_DEF
) (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_ready_i,
  input logic                           out_valid_i,
  input logic                           out_ready_i,
  input logic signed [aam_pkg::OUT_W-1:0] amp_a_i,
  input logic signed [aam_pkg::OUT_W-1:0] amp_b_i,
  input logic                           run_end_out_i,
  input logic                           saturated_i
);
  import aam_pkg::*;

  localparam int unsigned OUT_E   = out_exp(FRAC_BITS);
  localparam int unsigned MAX_FLY = 15;
  localparam int unsigned FLY_W   = 5;
  localparam logic signed [OUT_W-1:0] OUT_HI = OUT_W'((acc_t'(1) <<< OUT_E) - acc_t'(1));
  localparam logic signed [OUT_W-1:0] OUT_LO = OUT_W'(-(acc_t'(1) <<< OUT_E));

  logic [FLY_W-1:0] fly_q, fly_d;
  logic             in_xfer, out_xfer;

  assign in_xfer  = in_valid_i && in_ready_i;
  assign out_xfer = out_valid_i && out_ready_i;

  always_comb begin
    fly_d = fly_q;
    if (in_xfer && !out_xfer) begin
      fly_d = fly_q + FLY_W'(1);
    end else if (out_xfer && !in_xfer) begin
      fly_d = fly_q - FLY_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fly_q <= '0;
    end else begin
      fly_q <= fly_d;
    end
  end

  a_reset_quiet: assert property (@(posedge clk_i) !rst_ni |=> !out_valid_i)
    else $error("output valid during reset");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> fly_q != '0)
    else $error("result without a pending input transfer");

  a_bounded_fly: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fly_q <= FLY_W'(MAX_FLY))
    else $error("more samples in flight than pipeline and queue can hold");

  a_out_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (amp_a_i <= OUT_HI) && (amp_a_i >= OUT_LO)
                    && (amp_b_i <= OUT_HI) && (amp_b_i >= OUT_LO))
    else $error("output outside the clipping range");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(amp_a_i) && $stable(amp_b_i)
                                   && $stable(run_end_out_i) && $stable(saturated_i))
    else $error("stalled result changed");

endmodule

bind antenna_amplitude_modulation aam_checker #(
  .FRAC_BITS(FRAC_BITS)
) u_aam_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .amp_a_i      (out_o.amp_a),
  .amp_b_i      (out_o.amp_b),
  .run_end_out_i(out_o.run_end_out),
  .saturated_i  (out_o.saturated)
);

// ===== bench/amp_factor_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Amplitude modulation factor checker
// Watches the configuration port and both sample channels. It keeps its own
// copy of the detector registers and computes the expected factors a and b
// for every input transfer. It then compares each output transfer, field by
// field, with the oldest expected result.
// ----------------------------------------------------------------------------
module amp_factor_checker #(
  parameter int unsigned FRAC = aam_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [aam_pkg::REG_IDX_W-1:0] cfg_idx_i,
  input  logic [aam_pkg::IN_W-1:0]      cfg_data_i,
  aam_in_if                             in_mon,
  aam_out_if                            out_mon,
  output int                            err_cnt_o,
  output int                            pending_o
);
  import aam_pkg::*;

  localparam int unsigned SAT_E = (FRAC + 7 < 30) ? FRAC + 7 : 30;
  localparam longint MID_HI = (longint'(1) <<< SAT_E) - 1;
  localparam longint MID_LO = -MID_HI - 1;
  localparam longint AMP_LIM = ((longint'(8) <<< FRAC) < (longint'(1) <<< (OUT_W - 1))) ?
                               (longint'(8) <<< FRAC) : (longint'(1) <<< (OUT_W - 1));

  typedef struct packed {
    logic signed [OUT_W-1:0] amp_a;
    logic signed [OUT_W-1:0] amp_b;
    logic                    run_end;
    logic                    clipped;
  } amp_result_t;

  logic signed [IN_W-1:0] reg_q [7];
  amp_result_t            expected_q [$];
  amp_result_t            want_r;
  int                     mismatch_cnt;

  function automatic longint clamp_mid(input longint x);
    if (x > MID_HI) return MID_HI;
    if (x < MID_LO) return MID_LO;
    return x;
  endfunction

  function automatic longint round_q(input longint p);
    return clamp_mid((p + (longint'(1) <<< (FRAC - 1))) >>> FRAC);
  endfunction

  function automatic longint qmul(input longint x, input longint y);
    return round_q(x * y);
  endfunction

  function automatic longint qdot(input longint x, input longint y,
                                  input longint u, input longint v);
    return round_q(x * y + u * v);
  endfunction

  function automatic longint clip_amp(input longint x);
    if (x > AMP_LIM - 1) return AMP_LIM - 1;
    if (x < -AMP_LIM) return -AMP_LIM;
    return x;
  endfunction

  function automatic amp_result_t predict_factors(
    input logic signed [IN_W-1:0] sra, cra, sde, cde, cmo, smo,
    input logic                   run_end
  );
    longint c1, c2, c3, c4, c5, c6, c7, c8, c9, cph, sph;
    longint cr, sr, c2d, csd, rc, rs, c2s, cs2, kk, c1k, c6s, fa, fb;
    amp_result_t res;
    c1  = longint'(reg_q[REG_C1]);
    c2  = longint'(reg_q[REG_C2]);
    c3  = longint'(reg_q[REG_C3]);
    c4  = longint'(reg_q[REG_C4]);
    c5  = longint'(reg_q[REG_C5]);
    cph = longint'(reg_q[REG_CPH]);
    sph = longint'(reg_q[REG_SPH]);
    c6  = -2 * c2;
    c7  = 2 * c1;
    c8  = -c4;
    c9  = c3;
    cr  = qdot(longint'(cra), cph, longint'(sra), sph);
    sr  = qdot(longint'(sra), cph, -longint'(cra), sph);
    c2d = qmul(longint'(cde), longint'(cde));
    csd = qmul(longint'(sde), longint'(cde));
    rc  = qdot(cr, longint'(cmo), sr, longint'(smo));
    rs  = qdot(sr, longint'(cmo), -cr, longint'(smo));
    c2s = clamp_mid(2 * qmul(rc, rc));
    cs2 = clamp_mid(2 * qmul(rc, rs));
    kk  = clamp_mid((longint'(2) <<< FRAC) - c2d);
    c1k = qmul(c1, kk);
    fa  = qmul(c1k, c2s) + qmul(qmul(c2, kk), cs2) + qmul(qmul(c3, csd), rc)
          + qmul(qmul(c4, csd), rs) - c1k + qmul(c5, c2d);
    c6s = qmul(c6, longint'(sde));
    fb  = qmul(c6s, c2s) + qmul(qmul(c7, longint'(sde)), cs2)
          + qmul(qmul(c8, longint'(cde)), rc) + qmul(qmul(c9, longint'(cde)), rs) - c6s;
    res.clipped = (clip_amp(fa) != fa) || (clip_amp(fb) != fb);
    res.amp_a   = OUT_W'(clip_amp(fa));
    res.amp_b   = OUT_W'(clip_amp(fb));
    res.run_end = run_end;
    return res;
  endfunction

  task automatic check_field(input string tag, input logic [OUT_W-1:0] want,
                             input logic [OUT_W-1:0] got);
    if (got !== want) begin
      mismatch_cnt++;
      $display("%0t: %s expected %0d, actual %0d", $time, tag, $signed(want), $signed(got));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < 7; r++) begin
        reg_q[r] = '0;
      end
      reg_q[REG_CPH] = CPH_RST;
      expected_q.delete();
      mismatch_cnt = 0;
      err_cnt_o <= 0;
      pending_o <= 0;
    end else begin
      if (cfg_we_i && cfg_idx_i <= REG_SPH) begin
        reg_q[cfg_idx_i] = cfg_data_i;
      end
      if (in_mon.valid && in_mon.ready) begin
        expected_q.push_back(predict_factors(in_mon.sin_ra, in_mon.cos_ra, in_mon.sin_dec,
                                             in_mon.cos_dec, in_mon.cos_mod, in_mon.sin_mod,
                                             in_mon.run_end));
      end
      if (out_mon.valid && out_mon.ready) begin
        if (expected_q.size() == 0) begin
          mismatch_cnt++;
          $display("%0t: result transfer with none expected, actual a %0d b %0d",
                   $time, out_mon.amp_a, out_mon.amp_b);
        end else begin
          want_r = expected_q.pop_front();
          check_field("amp_a", want_r.amp_a, out_mon.amp_a);
          check_field("amp_b", want_r.amp_b, out_mon.amp_b);
          check_field("run_end_out", OUT_W'(want_r.run_end), OUT_W'(out_mon.run_end_out));
          check_field("saturated", OUT_W'(want_r.clipped), OUT_W'(out_mon.saturated));
        end
      end
      err_cnt_o <= mismatch_cnt;
      pending_o <= expected_q.size();
    end
  end

endmodule

// ===== bench/tb_antenna_amplitude_modulation.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Antenna amplitude modulation testbench
// Drives sky position samples through the block under a series of detector
// register settings, with random idle cycles on both channels, a long output
// stall and a full drain. A separate checker predicts every result and counts
// mismatches; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_antenna_amplitude_modulation;
  import aam_pkg::*;

  localparam int unsigned FRAC_BITS = FRAC_BITS_DEF;
  localparam int PIPE_LAT = 11;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES = 400;
  localparam int N_PHASES = 10;
  localparam int PHASE_ITEMS = 103;
  localparam logic [REG_IDX_W-1:0] REG_NONE = '1;

  typedef enum int {CFG_RANDOM, CFG_MAX, CFG_MIN, CFG_RAW, CFG_WILD} cfg_mode_e;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we;
  logic [REG_IDX_W-1:0] cfg_idx;
  logic [IN_W-1:0]      cfg_data;
  int                   err_cnt;
  int                   pending;
  int                   stall_cnt = 0;
  int                   send_burst = 0;
  int                   recv_burst = 0;
  int                   hold_req = 0;

  aam_in_if  in_if ();
  aam_out_if out_if ();

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  antenna_amplitude_modulation #(
    .FRAC_BITS (FRAC_BITS)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  amp_factor_checker #(
    .FRAC (FRAC_BITS)
  ) u_checker (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_mon     (in_if),
    .out_mon    (out_if),
    .err_cnt_o  (err_cnt),
    .pending_o  (pending)
  );

  function automatic logic signed [IN_W-1:0] ext_val(input int sel);
    case (sel % 5)
      0: return '0;
      1: return IN_W'(65536);
      2: return IN_W'(-65536);
      3: return IN_W'(131071);
      default: return IN_W'(-131072);
    endcase
  endfunction

  function automatic logic signed [IN_W-1:0] rand_q();
    int pick;
    int v;
    pick = $urandom_range(0, 9);
    if (pick < 7) begin
      v = int'($urandom_range(0, 131072)) - 65536;
      return IN_W'(v);
    end
    if (pick == 7) return IN_W'($urandom);
    return ext_val($urandom_range(0, 4));
  endfunction

  function automatic logic [IN_W-1:0] cfg_value(input cfg_mode_e mode);
    case (mode)
      CFG_MAX:  return IN_W'(65536);
      CFG_MIN:  return IN_W'(-65536);
      CFG_RAW:  return IN_W'($urandom);
      CFG_WILD: return ext_val($urandom_range(0, 4));
      default:  return IN_W'(int'($urandom_range(0, 131072)) - 65536);
    endcase
  endfunction

  task automatic push_sample(input logic signed [IN_W-1:0] sra, cra, sde, cde, cmo, smo,
                             input logic re);
    int gap;
    if (send_burst > 0) begin
      send_burst--;
      gap = 0;
    end else begin
      gap = $urandom_range(0, 19);
      if ($urandom_range(0, 15) == 0) send_burst = $urandom_range(10, 60);
    end
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid   <= 1'b1;
    in_if.sin_ra  <= sra;
    in_if.cos_ra  <= cra;
    in_if.sin_dec <= sde;
    in_if.cos_dec <= cde;
    in_if.cos_mod <= cmo;
    in_if.sin_mod <= smo;
    in_if.run_end <= re;
    do @(posedge clk); while (!in_if.ready);
  endtask

  task automatic run_random(input int n);
    for (int i = 0; i < n; i++) begin
      push_sample(rand_q(), rand_q(), rand_q(), rand_q(), rand_q(), rand_q(),
                  $urandom_range(0, 7) == 0);
    end
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [IN_W-1:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  // The stray write to the unused index must leave every register untouched.
  task automatic load_regs(input cfg_mode_e mode);
    for (int r = 0; r <= int'(REG_SPH); r++) begin
      write_reg(REG_IDX_W'(r), cfg_value(mode));
    end
    write_reg(REG_NONE, IN_W'($urandom));
    cfg_we <= 1'b0;
  endtask

  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  initial begin
    int gap;
    out_if.ready <= 1'b0;
    @(posedge rst_n);
    @(posedge clk);
    forever begin
      if (hold_req > 0) begin
        gap = hold_req;
        hold_req = 0;
      end else if (recv_burst > 0) begin
        recv_burst--;
        gap = 0;
      end else begin
        gap = $urandom_range(0, 19);
        if ($urandom_range(0, 15) == 0) recv_burst = $urandom_range(10, 60);
      end
      if (gap > 0) begin
        out_if.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (!out_if.valid);
    end
  end

  initial begin
    cfg_we        <= 1'b0;
    cfg_idx       <= '0;
    cfg_data      <= '0;
    in_if.valid   <= 1'b0;
    in_if.sin_ra  <= '0;
    in_if.cos_ra  <= '0;
    in_if.sin_dec <= '0;
    in_if.cos_dec <= '0;
    in_if.cos_mod <= '0;
    in_if.sin_mod <= '0;
    in_if.run_end <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Register defaults straight out of reset.
    run_random(3);
    drain();

    load_regs(CFG_MAX);
    for (int i = 0; i < 15; i++) begin
      push_sample(ext_val(i), ext_val(2 * i + 1), ext_val(3 * i + 2), ext_val(i + i / 5),
                  ext_val(4 * i + 3), ext_val(i / 3), i[0]);
    end
    drain();
    load_regs(CFG_MIN);
    for (int i = 0; i < 4; i++) begin
      push_sample(ext_val(i + 3), ext_val(i + 4), ext_val(i + 1), ext_val(2 * i + 3),
                  ext_val(i + 2), ext_val(3 * i + 1), ~i[0]);
    end

    for (int ph = 0; ph < N_PHASES; ph++) begin
      drain();
      load_regs(cfg_mode_e'(ph % 5));
      if (ph == 3) begin
        hold_req = HOLD_CYCLES;
        send_burst = 60;
      end
      if (ph == 6) begin
        run_random(PHASE_ITEMS / 2);
        drain();
        run_random(PHASE_ITEMS - PHASE_ITEMS / 2);
      end else begin
        run_random(PHASE_ITEMS);
      end
    end

    drain();
    repeat (PIPE_LAT + 20) @(posedge clk);
    if (err_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/aam_pkg.sv
sv/aam_in_if.sv
sv/aam_out_if.sv
sv/aam_front.sv
sv/aam_queue.sv
sv/aam_back.sv
sv/antenna_amplitude_modulation.sv
sv/aam_checker.sv
bench/amp_factor_checker.sv
bench/tb_antenna_amplitude_modulation.sv
